@@ rtl/tcce_pkg.sv @@
// Package for the text console cursor engine: field widths, byte codes,
// operation codes and the state and result structs shared by the RTL.
// No dependencies.
package tcce_pkg;

    localparam int COL_W       = 7;
    localparam int ROW_W       = 5;
    localparam int ADDR_W      = 11;
    localparam int WORD_W      = 16;
    localparam int COLOR_W     = 4;
    localparam int CHAR_W      = 8;
    localparam int OP_W        = 2;
    localparam int ADDR_CALC_W = 12;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 48;

    typedef enum logic [OP_W-1:0] {
        OP_CHAR       = 2'd0,
        OP_TEXT_COLOR = 2'd1,
        OP_BACK_COLOR = 2'd2
    } op_t;

    localparam logic [CHAR_W-1:0] CH_BELL       = 8'd7;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE  = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB        = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LINE_FEED  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_FORM_FEED  = 8'd12;
    localparam logic [CHAR_W-1:0] CH_CR         = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'd32;
    localparam logic [CHAR_W-1:0] CH_PRINT_LAST = 8'd126;

    localparam logic [COLOR_W-1:0] COLOR_WHITE = 4'd15;
    localparam logic [COLOR_W-1:0] COLOR_BLACK = 4'd0;

    typedef struct packed {
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [COLOR_W-1:0] text_color;
        logic [COLOR_W-1:0] back_color;
    } cursor_state_t;

    typedef struct packed {
        logic               cell_write;
        logic [ADDR_W-1:0]  cell_address;
        logic [WORD_W-1:0]  cell_word;
        logic               scroll_request;
        logic               clear_request;
        logic               beep_request;
        logic [COL_W-1:0]   cursor_column;
        logic [ROW_W-1:0]   cursor_row;
    } step_result_t;

endpackage

@@ rtl/text_console_cursor_engine.sv @@
// Top level of the text console cursor engine: input register, cursor and
// colour state, result register and stream handshakes.
// Depends on tcce_pkg and tcce_step.
//
//   Channel  Dir  Accept               Payload
//   s_*      in   s_tvalid & s_tready  tuser: operation; tdata: value
//   m_*      out  m_tvalid & m_tready  tuser: cell_write; tdata: address, word,
//                                      requests, cursor column and row
//
// A request passes from acceptance into the input register, then through the
// decode into the result register. A new request can enter every cycle while
// the result side does not stall; the cursor state advances as a request leaves
// the input register, so consecutive requests see each other's updates.
// A stalled result holds the result register and, one request later, the input
// register; s_tready falls only when both are full and m_tready is low.
// rst_n clears both valid flags, the cursor to the top left, colours to white
// on black.
module text_console_cursor_engine
    import tcce_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] value
    input  logic [OP_W-1:0]       s_tuser,   // [1:0] operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [10:0] cell_address, [26:11] cell_word, [27] scroll_request,
    // [28] clear_request, [29] beep_request, [36:30] cursor_column,
    // [41:37] cursor_row, [47:42] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser    // [0] cell_write
);

    logic              in_vld_reg;
    logic              in_vld_next;
    op_t               op_reg;
    logic [CHAR_W-1:0] value_reg;
    logic              out_vld_reg;
    logic              out_vld_next;
    step_result_t      res_reg;
    step_result_t      res_next;
    cursor_state_t     state_reg;
    cursor_state_t     state_next;
    logic              advance;
    logic              s_take;

    // move the held request into the result register when it is free
    assign advance  = in_vld_reg & (~out_vld_reg | m_tready);
    assign s_tready = ~in_vld_reg | advance;
    assign s_take   = s_tvalid & s_tready;

    assign in_vld_next  = s_take | (in_vld_reg & ~advance);
    assign out_vld_next = advance | (out_vld_reg & ~m_tready);

    tcce_step #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_step (
        .operation  (op_reg),
        .value      (value_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg           <= 1'b0;
            out_vld_reg          <= 1'b0;
            state_reg.col        <= '0;
            state_reg.row        <= '0;
            state_reg.text_color <= COLOR_WHITE;
            state_reg.back_color <= COLOR_BLACK;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            op_reg    <= op_t'(s_tuser);
            value_reg <= s_tdata[CHAR_W-1:0];
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = res_reg.cell_write;
    assign m_tdata  = {6'b0,
                       res_reg.cursor_row,
                       res_reg.cursor_column,
                       res_reg.beep_request,
                       res_reg.clear_request,
                       res_reg.scroll_request,
                       res_reg.cell_word,
                       res_reg.cell_address};

endmodule

@@ rtl/tcce_step.sv @@
// Single-item cursor update: decodes one request against the cursor and
// colour state and produces the next state and the result fields.
// Depends on tcce_pkg.
module tcce_step
    import tcce_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  op_t                operation,
    input  logic [CHAR_W-1:0]  value,
    input  cursor_state_t      state,
    output cursor_state_t      state_next,
    output step_result_t       result
);

    localparam logic [COL_W:0]   COLS_EXT = (COL_W+1)'(COLUMNS);
    localparam logic [ROW_W:0]   ROWS_EXT = (ROW_W+1)'(ROWS);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    logic [COL_W:0]       col_ext;
    logic [COL_W:0]       col_inc;
    logic [COL_W:0]       tab_col;
    logic [ROW_W:0]       row_ext;
    logic [ROW_W:0]       row_inc;
    logic [ROW_W:0]       row_after;
    logic                 col_wrap;
    logic                 lf_scroll;
    logic                 wr_scroll;
    logic [ADDR_CALC_W-1:0] addr_full;
    logic [CHAR_W-1:0]    glyph;

    assign col_ext   = {1'b0, state.col};
    assign row_ext   = {1'b0, state.row};
    assign col_inc   = col_ext + 1'b1;
    // next stop of eight: clear the low three bits and step one stop
    assign tab_col   = {col_ext[COL_W:3] + 1'b1, 3'b000};
    assign row_inc   = row_ext + 1'b1;
    assign col_wrap  = (col_inc >= COLS_EXT);
    assign row_after = col_wrap ? row_inc : row_ext;
    assign lf_scroll = (row_inc >= ROWS_EXT);
    assign wr_scroll = (row_after >= ROWS_EXT);
    assign addr_full = ADDR_CALC_W'(state.row) * ADDR_CALC_W'(COLUMNS)
                     + ADDR_CALC_W'(state.col);
    assign glyph     = (value >= CH_SPACE && value <= CH_PRINT_LAST) ? value : CH_SPACE;

    always_comb
    begin
        state_next = state;
        result     = '0;
        case (operation)
            OP_TEXT_COLOR: state_next.text_color = value[COLOR_W-1:0];
            OP_BACK_COLOR: state_next.back_color = value[COLOR_W-1:0];
            OP_CHAR:
            begin
                case (value)
                    CH_BELL: result.beep_request = 1'b1;
                    CH_BACKSPACE:
                    begin
                        if (state.col != '0)
                        begin
                            state_next.col = state.col - 1'b1;
                        end
                    end
                    CH_TAB:
                    begin
                        state_next.col = (tab_col >= COLS_EXT) ? LAST_COL
                                                               : tab_col[COL_W-1:0];
                    end
                    CH_LINE_FEED:
                    begin
                        state_next.col        = '0;
                        result.scroll_request = lf_scroll;
                        state_next.row        = lf_scroll ? LAST_ROW : row_inc[ROW_W-1:0];
                    end
                    CH_FORM_FEED:
                    begin
                        state_next.col        = '0;
                        state_next.row        = '0;
                        state_next.text_color = COLOR_WHITE;
                        state_next.back_color = COLOR_BLACK;
                        result.clear_request  = 1'b1;
                    end
                    CH_CR: state_next.col = '0;
                    default:
                    begin
                        result.cell_write     = 1'b1;
                        result.cell_address   = addr_full[ADDR_W-1:0];
                        result.cell_word      = {state.back_color, state.text_color, glyph};
                        state_next.col        = col_wrap ? '0 : col_inc[COL_W-1:0];
                        result.scroll_request = wr_scroll;
                        state_next.row        = wr_scroll ? LAST_ROW : row_after[ROW_W-1:0];
                    end
                endcase
            end
            default: ;
        endcase
        result.cursor_column = state_next.col;
        result.cursor_row    = state_next.row;
    end

endmodule

@@ dv/tb_text_console_cursor_engine.sv @@
// Self-checking testbench for text_console_cursor_engine: random stream stalls
// on both sides, with a transaction-level cursor and colour predictor in the bench.
// Depends on tcce_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_text_console_cursor_engine;
    import tcce_pkg::*;

    localparam int TERM_COLS    = DEF_COLUMNS;
    localparam int TERM_ROWS    = DEF_ROWS;
    localparam int TAB_STOP     = 8;
    localparam int ITEM_TARGET  = 800;
    localparam int TAIL_ITEMS   = 100;   // last requests go in back to back
    localparam int MAX_REPORTS  = 10;
    localparam int STALL_LIMIT  = 500;   // cycles with no handshake at all
    localparam int DRAIN_CYCLES = 8;

    // operation code the block must ignore
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] value;
    } console_req_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    text_console_cursor_engine #(
        .COLUMNS (TERM_COLS),
        .ROWS    (TERM_ROWS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Requests still to be sent, and predicted results still to arrive
    console_req_t byte_requests[$];
    step_result_t cursor_results_due[$];

    // Predictor state: cursor position and current colours
    int               cur_col;
    int               cur_row;
    logic [COLOR_W-1:0] txt_color;
    logic [COLOR_W-1:0] bg_color;

    int           fail_count   = 0;
    int           results_seen = 0;
    int           total_items  = 0;
    int           sent_count   = 0;
    int           stall_cycles = 0;
    int           idle_pct     = 20;
    int           valid_gap    = 0;
    int           ready_gap    = 0;
    bit           tail_phase   = 1'b0;
    logic         req_taken    = 1'b0;
    console_req_t next_req;
    step_result_t want_res;
    step_result_t seen_res;

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Wrap the column onto the next row, hold the row on the last line and
    // flag a scroll when it runs off the bottom.
    function automatic logic settle_position();
        logic scrolled;
        scrolled = 1'b0;
        if (cur_col >= TERM_COLS)
        begin
            cur_col = 0;
            cur_row = cur_row + 1;
        end
        if (cur_row >= TERM_ROWS)
        begin
            scrolled = 1'b1;
            cur_row  = TERM_ROWS - 1;
        end
        return scrolled;
    endfunction

    // Apply one request to the predictor state and return the result that
    // the block must produce for it.
    function automatic step_result_t console_step(input logic [OP_W-1:0] op,
                                                  input logic [CHAR_W-1:0] v);
        step_result_t      r;
        logic [CHAR_W-1:0] glyph;
        r = '0;
        case (op)
            OP_TEXT_COLOR: txt_color = v[COLOR_W-1:0];
            OP_BACK_COLOR: bg_color  = v[COLOR_W-1:0];
            OP_CHAR:
            begin
                case (v)
                    CH_BELL: r.beep_request = 1'b1;
                    CH_BACKSPACE:
                    begin
                        if (cur_col > 0)
                            cur_col = cur_col - 1;
                    end
                    CH_TAB:
                    begin
                        cur_col = (cur_col / TAB_STOP + 1) * TAB_STOP;
                        if (cur_col >= TERM_COLS)
                            cur_col = TERM_COLS - 1;
                    end
                    CH_LINE_FEED:
                    begin
                        cur_col = 0;
                        cur_row = cur_row + 1;
                        r.scroll_request = settle_position();
                    end
                    CH_FORM_FEED:
                    begin
                        cur_col   = 0;
                        cur_row   = 0;
                        txt_color = COLOR_WHITE;
                        bg_color  = COLOR_BLACK;
                        r.clear_request = 1'b1;
                    end
                    CH_CR: cur_col = 0;
                    default:
                    begin
                        // anything outside the printable range is drawn blank
                        glyph = (v >= CH_SPACE && v <= CH_PRINT_LAST) ? v : CH_SPACE;
                        r.cell_write   = 1'b1;
                        r.cell_address = ADDR_W'(cur_row * TERM_COLS + cur_col);
                        r.cell_word    = {bg_color, txt_color, glyph};
                        cur_col = cur_col + 1;
                        r.scroll_request = settle_position();
                    end
                endcase
            end
            default: ;  // spare operation: state untouched, no requests
        endcase
        r.cursor_column = COL_W'(cur_col);
        r.cursor_row    = ROW_W'(cur_row);
        return r;
    endfunction

    task automatic push_req(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] value);
        console_req_t q;
        q.op    = op;
        q.value = value;
        byte_requests.push_back(q);
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned seen);
        if (want != seen)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("mismatch at result %0d, %s: expected 0x%0h, got 0x%0h",
                         results_seen, field, want, seen);
        end
    endtask

    // Driver: change inputs on the falling edge only. Advance the request when
    // the last rising edge took it, otherwise hold it steady.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            tail_phase = (byte_requests.size() < TAIL_ITEMS);

            // result side: hold m_tready low in random bursts, counted down in ready_gap
            if (ready_gap > 0)
            begin
                m_tready <= 1'b0;
                ready_gap = ready_gap - 1;
            end
            else if (!tail_phase && $urandom_range(0, 99) < idle_pct)
            begin
                m_tready <= 1'b0;
                ready_gap = $urandom_range(0, 3);
            end
            else
            begin
                m_tready <= 1'b1;
            end

            // request side: only move on once the current request is taken
            if (!s_tvalid || req_taken)
            begin
                if (valid_gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    valid_gap = valid_gap - 1;
                end
                else if (byte_requests.size() == 0)
                begin
                    s_tvalid <= 1'b0;
                end
                else if (!tail_phase && $urandom_range(0, 99) < idle_pct)
                begin
                    s_tvalid <= 1'b0;
                    valid_gap = $urandom_range(0, 3);
                end
                else
                begin
                    next_req = byte_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_req.op;
                    s_tdata  <= next_req.value;
                    sent_count = sent_count + 1;
                    // vary the idle density, including stretches with none
                    if (sent_count % 50 == 0)
                        idle_pct = $urandom_range(0, 3) * 12;
                end
            end
        end
    end

    // Monitor: sample both handshakes on the rising edge, predict on request
    // acceptance, compare on result acceptance.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                cursor_results_due.push_back(console_step(s_tuser, s_tdata));

            if (m_tvalid && m_tready)
            begin
                // tuser: cell_write; tdata low to high: address, word,
                // scroll, clear, beep, column, row
                seen_res.cell_write     = m_tuser;
                seen_res.cell_address   = m_tdata[10:0];
                seen_res.cell_word      = m_tdata[26:11];
                seen_res.scroll_request = m_tdata[27];
                seen_res.clear_request  = m_tdata[28];
                seen_res.beep_request   = m_tdata[29];
                seen_res.cursor_column  = m_tdata[36:30];
                seen_res.cursor_row     = m_tdata[41:37];
                if (cursor_results_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result %0d: tuser 0x%0h tdata 0x%0h",
                                 results_seen, m_tuser, m_tdata);
                end
                else
                begin
                    want_res = cursor_results_due.pop_front();
                    check_field("cell_write", 32'(want_res.cell_write),
                                32'(seen_res.cell_write));
                    check_field("cell_address", 32'(want_res.cell_address),
                                32'(seen_res.cell_address));
                    check_field("cell_word", 32'(want_res.cell_word),
                                32'(seen_res.cell_word));
                    check_field("scroll_request", 32'(want_res.scroll_request),
                                32'(seen_res.scroll_request));
                    check_field("clear_request", 32'(want_res.clear_request),
                                32'(seen_res.clear_request));
                    check_field("beep_request", 32'(want_res.beep_request),
                                32'(seen_res.beep_request));
                    check_field("cursor_column", 32'(want_res.cursor_column),
                                32'(seen_res.cursor_column));
                    check_field("cursor_row", 32'(want_res.cursor_row),
                                32'(seen_res.cursor_row));
                end
                results_seen <= results_seen + 1;
            end

            // watchdog: drop the run if neither side moves for too long
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial
    begin
        int n;
        int i;
        // reset state of the predictor: top left, white on black
        cur_col   = 0;
        cur_row   = 0;
        txt_color = COLOR_WHITE;
        bg_color  = COLOR_BLACK;

        // Directed opening: colours with junk in the high nibble, printable
        // edges, bytes drawn blank, every control byte, the spare operation,
        // backspace at column zero and a clear that restores the colours.
        push_req(OP_TEXT_COLOR, 8'hF3);
        push_req(OP_BACK_COLOR, 8'hFA);
        push_req(OP_CHAR, 8'h41);
        push_req(OP_CHAR, CH_PRINT_LAST);
        push_req(OP_CHAR, CH_SPACE);
        push_req(OP_CHAR, 8'd127);
        push_req(OP_CHAR, 8'd0);
        push_req(OP_CHAR, 8'd255);
        push_req(OP_CHAR, 8'd128);
        push_req(OP_CHAR, 8'd31);
        push_req(OP_CHAR, CH_BELL);
        push_req(OP_CHAR, CH_BACKSPACE);
        push_req(OP_CHAR, CH_CR);
        push_req(OP_CHAR, CH_BACKSPACE);
        push_req(OP_CHAR, CH_TAB);
        push_req(OP_CHAR, CH_LINE_FEED);
        push_req(OP_SPARE, 8'hFF);
        push_req(OP_SPARE, 8'h00);
        push_req(OP_CHAR, 8'h5A);
        push_req(OP_CHAR, CH_FORM_FEED);
        push_req(OP_CHAR, 8'h5A);
        push_req(OP_TEXT_COLOR, 8'h00);
        push_req(OP_BACK_COLOR, 8'h0F);
        push_req(OP_CHAR, 8'h7E);

        // Random part: mostly well-formed runs (lines of text, line feed and
        // tab bursts) so the cursor reaches the right edge and the bottom row,
        // mixed with single noise requests.
        while (byte_requests.size() < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    n = $urandom_range(1, 90);
                    for (i = 0; i < n; i++)
                    begin
                        if ($urandom_range(0, 15) == 0)
                            push_req(OP_CHAR, CHAR_W'($urandom_range(0, 255)));
                        else
                            push_req(OP_CHAR,
                                     CHAR_W'($urandom_range(CH_SPACE, CH_PRINT_LAST)));
                    end
                end
                3:
                begin
                    n = $urandom_range(1, 30);
                    for (i = 0; i < n; i++)
                        push_req(OP_CHAR, CH_LINE_FEED);
                end
                4:
                begin
                    n = $urandom_range(1, 12);
                    for (i = 0; i < n; i++)
                        push_req(OP_CHAR, CH_TAB);
                end
                5:
                begin
                    n = $urandom_range(1, 6);
                    for (i = 0; i < n; i++)
                        push_req(OP_CHAR, CH_BACKSPACE);
                end
                6:
                begin
                    push_req(OP_TEXT_COLOR, CHAR_W'($urandom_range(0, 255)));
                    push_req(OP_BACK_COLOR, CHAR_W'($urandom_range(0, 255)));
                end
                7: push_req(OP_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)));
                8:
                begin
                    case ($urandom_range(0, 2))
                        0: push_req(OP_CHAR, CH_BELL);
                        1: push_req(OP_CHAR, CH_CR);
                        default: push_req(OP_CHAR, CH_LINE_FEED);
                    endcase
                end
                default:
                begin
                    // clears kept rare so the rows can fill between them
                    if ($urandom_range(0, 5) == 0)
                        push_req(OP_CHAR, CH_FORM_FEED);
                    else
                        push_req(OP_CHAR, CHAR_W'($urandom_range(0, 255)));
                end
            endcase
        end
        total_items = byte_requests.size();

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // wait for every result, then DRAIN_CYCLES longer for strays
        while (results_seen < total_items)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (cursor_results_due.size() != 0)
            fail_count++;

        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
